// ----- design/sstd_pkg.sv -----
package sstd_pkg;

  localparam logic [2:0] OP_INIT   = 3'd0;
  localparam logic [2:0] OP_TIME   = 3'd1;
  localparam logic [2:0] OP_DATE   = 3'd2;
  localparam logic [2:0] OP_INTENS = 3'd3;
  localparam logic [2:0] OP_OFF    = 3'd4;

  localparam logic [3:0] CODE_DASH  = 4'hA;
  localparam logic [3:0] CODE_BLANK = 4'hF;
  localparam logic [3:0] POS_INTENS = 4'hA;

  localparam logic [6:0]  MAX_2DIG = 7'd99;
  localparam logic [13:0] MAX_4DIG = 14'd9999;

  localparam logic [2:0] INIT_LAST_IDX = 3'd4;
  localparam logic [2:0] RUN_LAST_IDX  = 3'd7;

  typedef enum logic [2:0] {
    K_INIT   = 3'd0,
    K_TIME   = 3'd1,
    K_DATE   = 3'd2,
    K_INTENS = 3'd3,
    K_OFF    = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e           kind;
    logic [7:0][3:0] codes;
  } entry_t;

  function automatic logic [9:0] div10_w14(input logic [13:0] v);
    logic [29:0] p;
    p = 30'(v) * 30'd52429;
    return p[28:19];
  endfunction

  function automatic logic [6:0] div10_w10(input logic [9:0] v);
    logic [17:0] p;
    p = 18'(v) * 18'd205;
    return p[17:11];
  endfunction

  function automatic logic [3:0] div10_w7(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [11:0] init_word(input logic [2:0] idx);
    logic [11:0] w;
    unique case (idx)
      3'd0:    w = 12'hC11;
      3'd1:    w = 12'hB17;
      3'd2:    w = 12'h9FF;
      3'd3:    w = 12'hA1F;
      default: w = 12'hF00;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] time_pos(input logic [2:0] idx);
    logic [3:0] p;
    unique case (idx)
      3'd0:    p = 4'd6;
      3'd1:    p = 4'd3;
      3'd2:    p = 4'd8;
      3'd3:    p = 4'd7;
      3'd4:    p = 4'd5;
      3'd5:    p = 4'd4;
      3'd6:    p = 4'd2;
      default: p = 4'd1;
    endcase
    return p;
  endfunction

endpackage

// ----- design/sstd_front.sv -----
module sstd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        op_i,
  input  logic [6:0]        first_value_i,
  input  logic [6:0]        second_value_i,
  input  logic [13:0]       third_value_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output sstd_pkg::entry_t  push_entry_o
);

  typedef struct packed {
    sstd_pkg::kind_e kind;
    logic            keep;
    logic [3:0]      at;
    logic [3:0]      au;
    logic [3:0]      bt;
    logic [3:0]      bu;
    logic [3:0]      icode;
    logic [13:0]     c;
    logic [3:0]      r0;
    logic [3:0]      r1;
  } stage_t;

  logic   s1_v_q, s2_v_q, s3_v_q;
  stage_t s1_q, s2_q, s3_q;
  stage_t s1_d, s2_d, s3_d;
  logic   adv, s3_fire;

  logic [2:0]  op_sat;
  logic [6:0]  a_sat, b_sat;
  logic [9:0]  c1;
  logic [6:0]  c2;
  logic [3:0]  c3, r2;

  assign s3_fire    = s3_v_q && (!s3_q.keep || push_ready_i);
  assign adv        = !s3_v_q || s3_fire;
  assign in_ready_o = adv;

  always_comb begin
    op_sat = (op_i > sstd_pkg::OP_OFF) ? sstd_pkg::OP_OFF : op_i;
    a_sat  = (first_value_i > sstd_pkg::MAX_2DIG) ? sstd_pkg::MAX_2DIG : first_value_i;
    b_sat  = (second_value_i > sstd_pkg::MAX_2DIG) ? sstd_pkg::MAX_2DIG : second_value_i;
    s1_d       = '0;
    s1_d.keep  = 1'b1;
    s1_d.at    = sstd_pkg::div10_w7(a_sat);
    s1_d.au    = 4'(a_sat - 7'(s1_d.at) * 7'd10);
    s1_d.bt    = sstd_pkg::div10_w7(b_sat);
    s1_d.bu    = 4'(b_sat - 7'(s1_d.bt) * 7'd10);
    unique case (op_sat)
      sstd_pkg::OP_INIT: s1_d.kind = sstd_pkg::K_INIT;
      sstd_pkg::OP_TIME: begin
        s1_d.kind = sstd_pkg::K_TIME;
        s1_d.c    = (third_value_i > 14'(sstd_pkg::MAX_2DIG)) ?
                    14'(sstd_pkg::MAX_2DIG) : third_value_i;
      end
      sstd_pkg::OP_DATE: begin
        s1_d.kind = sstd_pkg::K_DATE;
        s1_d.c    = (third_value_i > sstd_pkg::MAX_4DIG) ? sstd_pkg::MAX_4DIG : third_value_i;
      end
      sstd_pkg::OP_INTENS: s1_d.kind = sstd_pkg::K_INTENS;
      default:             s1_d.kind = sstd_pkg::K_OFF;
    endcase
    unique case (first_value_i)
      7'd1:    s1_d.icode = 4'h1;
      7'd2:    s1_d.icode = 4'h4;
      7'd3:    s1_d.icode = 4'h8;
      7'd4:    s1_d.icode = 4'hD;
      default: begin
        s1_d.icode = 4'h0;
        if (op_sat == sstd_pkg::OP_INTENS) s1_d.keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    s2_d    = s1_q;
    c1      = sstd_pkg::div10_w14(s1_q.c);
    s2_d.c  = 14'(c1);
    s2_d.r0 = 4'(s1_q.c - 14'(c1) * 14'd10);
  end

  always_comb begin
    s3_d    = s2_q;
    c2      = sstd_pkg::div10_w10(s2_q.c[9:0]);
    s3_d.c  = 14'(c2);
    s3_d.r1 = 4'(s2_q.c[9:0] - 10'(c2) * 10'd10);
  end

  always_comb begin
    c3 = sstd_pkg::div10_w7(s3_q.c[6:0]);
    r2 = 4'(s3_q.c[6:0] - 7'(c3) * 7'd10);
    push_entry_o.kind = s3_q.kind;
    unique case (s3_q.kind)
      sstd_pkg::K_TIME: push_entry_o.codes = {s3_q.r0, s3_q.r1, s3_q.bu, s3_q.bt,
                                              s3_q.au, s3_q.at, sstd_pkg::CODE_DASH,
                                              sstd_pkg::CODE_DASH};
      sstd_pkg::K_DATE: push_entry_o.codes = {s3_q.r0, s3_q.r1, r2, c3,
                                              s3_q.bu, s3_q.bt, s3_q.au, s3_q.at};
      sstd_pkg::K_INTENS: push_entry_o.codes = {28'h0, s3_q.icode};
      sstd_pkg::K_OFF:  push_entry_o.codes = {8{sstd_pkg::CODE_BLANK}};
      default:          push_entry_o.codes = '0;
    endcase
  end

  assign push_valid_o = s3_v_q && s3_q.keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
    end
  end

endmodule

// ----- design/sstd_queue.sv -----
module sstd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  sstd_pkg::entry_t  push_entry_i,
  output logic              head_valid_o,
  input  logic              pop_i,
  output sstd_pkg::entry_t  head_entry_o
);

  sstd_pkg::entry_t mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_entry_o = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_entry_i;
  end

endmodule

// ----- design/sstd_back.sv -----
module sstd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  sstd_pkg::entry_t  head_entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [11:0]       display_word_o,
  output logic              last_word_o
);

  logic [2:0]  idx_q, idx_d;
  logic        ov_q;
  logic [11:0] word_q, word_d;
  logic        last_q, last_d;
  logic        fire;
  logic [3:0]  code, pos;
  logic        pt;

  assign fire = head_valid_i && (!ov_q || out_ready_i);
  assign code = head_entry_i.codes[idx_q];

  always_comb begin
    pt     = 1'b0;
    pos    = 4'd8 - 4'(idx_q);
    word_d = {pos, pt, 3'b000, code};
    last_d = (idx_q == sstd_pkg::RUN_LAST_IDX);
    unique case (head_entry_i.kind)
      sstd_pkg::K_INIT: begin
        word_d = sstd_pkg::init_word(idx_q);
        last_d = (idx_q == sstd_pkg::INIT_LAST_IDX);
      end
      sstd_pkg::K_TIME: word_d = {sstd_pkg::time_pos(idx_q), 4'b0000, code};
      sstd_pkg::K_DATE: begin
        pt     = (idx_q == 3'd1) || (idx_q == 3'd3);
        word_d = {pos, pt, 3'b000, code};
      end
      sstd_pkg::K_INTENS: begin
        word_d = {sstd_pkg::POS_INTENS, 4'b0000, code};
        last_d = 1'b1;
      end
      default: word_d = {pos, 4'b0000, code};
    endcase
    idx_d = last_d ? 3'd0 : idx_q + 3'd1;
  end

  assign pop_o          = fire && last_d;
  assign out_valid_o    = ov_q;
  assign display_word_o = word_q;
  assign last_word_o    = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      idx_q <= 3'd0;
    end else if (fire) begin
      ov_q  <= 1'b1;
      idx_q <= idx_d;
    end else if (out_ready_i) begin
      ov_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      word_q <= word_d;
      last_q <= last_d;
    end
  end

endmodule

// ----- design/seven_segment_time_date_formatter_core.sv -----
// Seven-segment time/date formatter.
// Input channel (in_valid_i/in_ready_o): one command beat with op and three
// values. Output channel (out_valid_o/out_ready_i): one 12-bit driver word per
// beat, last_word_o set on the final word of each command's run.
// Runs: init 5 words, time 8, date 8, all off 8, intensity 1 word for levels
// 1-4 and none otherwise. Out-of-range op and values are saturated.
// The first word of a run passes through three digit-split stages, one queue
// slot and the output register.
// Throughput: the word emitter sends one word per cycle while the receiver is
// ready; the front pipeline and a 2-entry command queue keep taking commands
// while words drain.
// Receiver stall: the output register holds its word; the queue fills, then
// the front pipeline stops and in_ready_o drops.
// Reset: pipeline, queue and output register empty; no words pending.
module seven_segment_time_date_formatter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [6:0]  first_value_i,
  input  logic [6:0]  second_value_i,
  input  logic [13:0] third_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] display_word_o,
  output logic        last_word_o
);

  logic             push_valid, push_ready, head_valid, pop;
  sstd_pkg::entry_t push_entry, head_entry;

  sstd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .third_value_i  (third_value_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_entry_o   (push_entry)
  );

  sstd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_entry_o (head_entry)
  );

  sstd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_entry_i   (head_entry),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .display_word_o (display_word_o),
    .last_word_o    (last_word_o)
  );

endmodule

// ----- design/sstd_checker.sv -----
module sstd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [11:0] display_word_o,
  input logic        last_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(display_word_o) && $stable(last_word_o))
    else $error("output beat changed while stalled");

  a_intens_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && display_word_o[11:4] == 8'hA0 |-> last_word_o)
    else $error("intensity word not flagged last");

  a_point_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && display_word_o[7] && display_word_o[11:8] != 4'h9 |->
      (display_word_o[11:8] == 4'd7 || display_word_o[11:8] == 4'd5) &&
      display_word_o[3:0] <= 4'd9)
    else $error("decimal point on wrong digit");

  a_digit_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && display_word_o[11:8] >= 4'd1 && display_word_o[11:8] <= 4'd8 |->
      display_word_o[3:0] <= 4'hA || display_word_o[3:0] == 4'hF)
    else $error("bad digit code");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_word_o && display_word_o[11:8] != 4'hF &&
      display_word_o[11:8] != 4'hA |-> display_word_o[11:8] == 4'd1)
    else $error("digit run ended on wrong position");

endmodule

bind seven_segment_time_date_formatter_core sstd_checker u_sstd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .display_word_o (display_word_o),
  .last_word_o    (last_word_o)
);
